// File: hdl/dvp_pkg.sv
`default_nettype none

package dvp_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned DCNT_W    = 4;
  localparam int unsigned PART_W    = 2;
  localparam int unsigned PROD_W    = VAL_W + 4;

  localparam logic [DCNT_W-1:0] MAX_DIGITS = DCNT_W'(10);
  localparam logic [PART_W-1:0] LAST_PART  = PART_W'(2);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_V = 8'h76;
  localparam logic [CHAR_W-1:0] CH_UP_V  = 8'h56;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              no_char;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] major_value;
    logic [VAL_W-1:0] minor_value;
    logic [VAL_W-1:0] patch_value;
  } result_t;

  typedef struct packed {
    logic              at_start;
    logic [PART_W-1:0] part_number;
    logic [DCNT_W-1:0] digit_count;
    logic              leads_with_zero;
    logic [VAL_W-1:0]  accumulator;
    logic              failed;
    logic [VAL_W-1:0]  held_major;
    logic [VAL_W-1:0]  held_minor;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    at_start:        1'b1,
    part_number:     '0,
    digit_count:     '0,
    leads_with_zero: 1'b0,
    accumulator:     '0,
    failed:          1'b0,
    held_major:      '0,
    held_minor:      '0
  };

endpackage

`default_nettype wire

// File: hdl/dvp_in_stage.sv
`default_nettype none

module dvp_in_stage
  import dvp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     take,
  output logic          item_valid,
  output in_item_t      item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: hdl/dvp_parser.sv
`default_nettype none

module dvp_parser
  import dvp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     item_valid,
  input  wire in_item_t item,
  input  wire logic     out_space,
  output logic          take,
  output logic          res_valid,
  output result_t       res
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  parse_state_t upd;
  logic [CHAR_W-1:0] ch;
  logic [3:0]        digit;
  logic [PROD_W-1:0] prod;
  logic              good;

  assign take      = item_valid && (!item.end_of_text || out_space);
  assign res_valid = take && item.end_of_text;

  assign ch    = item.character;
  assign digit = 4'(ch - CH_ZERO);
  // acc * 10 + digit as shifts and adds
  assign prod  = {st_r.accumulator, 3'b000} + {2'b00, st_r.accumulator, 1'b0}
               + PROD_W'(digit);

  always_comb begin
    upd = st_r;
    if (!item.no_char) begin
      upd.at_start = 1'b0;
      if (st_r.failed) begin
        upd.failed = 1'b1;
      end else if (st_r.at_start && (ch == CH_LOW_V || ch == CH_UP_V)) begin
        upd.failed = 1'b0;
      end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
        if (st_r.digit_count >= MAX_DIGITS
            || (st_r.digit_count != '0 && st_r.leads_with_zero)) begin
          upd.failed = 1'b1;
        end else if (prod[PROD_W-1:VAL_W] != '0) begin
          upd.failed = 1'b1;
        end else begin
          if (st_r.digit_count == '0) begin
            upd.leads_with_zero = (ch == CH_ZERO);
          end
          upd.accumulator = prod[VAL_W-1:0];
          upd.digit_count = st_r.digit_count + DCNT_W'(1);
        end
      end else if (ch == CH_DOT) begin
        if (st_r.digit_count == '0 || st_r.part_number >= LAST_PART) begin
          upd.failed = 1'b1;
        end else begin
          if (st_r.part_number == '0) begin
            upd.held_major = st_r.accumulator;
          end else begin
            upd.held_minor = st_r.accumulator;
          end
          upd.part_number     = st_r.part_number + PART_W'(1);
          upd.digit_count     = '0;
          upd.leads_with_zero = 1'b0;
          upd.accumulator     = '0;
        end
      end else begin
        upd.failed = 1'b1;
      end
    end
  end

  assign good = !upd.failed && upd.part_number == LAST_PART && upd.digit_count != '0;

  always_comb begin
    res.ok          = good;
    res.major_value = good ? upd.held_major  : '0;
    res.minor_value = good ? upd.held_minor  : '0;
    res.patch_value = good ? upd.accumulator : '0;
  end

  always_comb begin
    st_nxt = st_r;
    if (take) begin
      st_nxt = item.end_of_text ? PARSE_RESET : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PARSE_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dvp_out_stage.sv
`default_nettype none

module dvp_out_stage
  import dvp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         out_space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign out_space = !valid_r || out_ready;
  assign valid_nxt = res_valid ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// File: hdl/dotted_version_parser_core.sv
// Dotted version parser. Feed a version string one byte per transaction
// (in_character), flagging the final one with in_end_of_text; exactly one
// result transaction comes out for each string, carrying out_ok and the
// major, minor and patch numbers (all zero unless out_ok). Accepted form:
// an optional leading 'v' or 'V', then three decimal parts split by two
// dots, each 1 to 10 digits, no leading zero except a lone 0, and each at
// most 4294967295. An empty string is sent as a single transaction with
// in_no_char and in_end_of_text set and reports not ok; a no_char
// transaction that is not last is ignored. Throughput is one byte per
// cycle, but a last byte waits on a full result register; the per-byte
// multiply-by-ten, overflow check and state update sit between the input
// register and the parse-state/result registers. Both channels use
// valid/ready; the output register lets the next string start while a
// result waits for out_ready.
`default_nettype none

module dotted_version_parser_core
  import dvp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CHAR_W-1:0] in_character,
  input  wire logic              in_no_char,
  input  wire logic              in_end_of_text,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_ok,
  output logic [VAL_W-1:0]       out_major_value,
  output logic [VAL_W-1:0]       out_minor_value,
  output logic [VAL_W-1:0]       out_patch_value
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     take;
  logic     out_space;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.character   = in_character;
  assign in_item.no_char     = in_no_char;
  assign in_item.end_of_text = in_end_of_text;

  // input register; refilled in the same cycle the parser consumes it
  dvp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // parse state and per-byte step; stalls only on a last byte when the
  // result register is full and not being drained
  dvp_parser u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_space  (out_space),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  dvp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_space (out_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_ok          = out_res.ok;
  assign out_major_value = out_res.major_value;
  assign out_minor_value = out_res.minor_value;
  assign out_patch_value = out_res.patch_value;

endmodule

`default_nettype wire

// File: hdl/dvp_checker.sv
`default_nettype none

module dvp_checker
  import dvp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [CHAR_W-1:0] in_character,
  input wire logic              in_no_char,
  input wire logic              in_end_of_text,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_ok,
  input wire logic [VAL_W-1:0]  out_major_value,
  input wire logic [VAL_W-1:0]  out_minor_value,
  input wire logic [VAL_W-1:0]  out_patch_value
);

  // a failed parse reports all numbers as zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_major_value == '0 && out_minor_value == '0
                             && out_patch_value == '0)
    else $error("not-ok result carries nonzero value");

  // with the result register empty nothing can block the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok)
      && $stable(out_major_value) && $stable(out_minor_value)
      && $stable(out_patch_value))
    else $error("stalled result changed");

  // a waiting input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_character)
      && $stable(in_no_char) && $stable(in_end_of_text))
    else $error("stalled input changed");

endmodule

bind dotted_version_parser_core dvp_checker u_dvp_checker (.*);

`default_nettype wire
